// File: rtl/linked_slot_message_queue_macros.svh
// Assertion helpers for the queue RTL.
`ifndef LINKED_SLOT_MESSAGE_QUEUE_MACROS_SVH
`define LINKED_SLOT_MESSAGE_QUEUE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset.
`define LSMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define LSMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSMQ_ASSERT(lbl, prop, msg)
`define LSMQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/lsmq_pkg.sv
package lsmq_pkg;

  localparam int DATA_W      = 64;
  localparam int MAX_RESULTS = 8;
  localparam int KW          = $clog2(MAX_RESULTS);
  localparam int WCW         = $clog2(MAX_RESULTS + 1);

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // What the output register is loaded with
  typedef enum logic [1:0] {
    RESP_OK,
    RESP_FULL,
    RESP_EMPTY,
    RESP_WORD
  } resp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ALLOC,
    S_WLO,
    S_WHI,
    S_LINK0,
    S_LINK1,
    S_PUT_OK,
    S_PUT_FULL,
    S_GET_EMPTY,
    S_GET_RD0,
    S_GET_RD1,
    S_UNLINK,
    S_GET_ZERO,
    S_WORD_RD,
    S_WORD_OUT,
    S_RESP_WAIT,
    S_WORD_WAIT
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  alloc_step;
    logic  put_wlo;
    logic  put_whi;
    logic  link0;
    logic  link1;
    logic  put_full;
    logic  get_rd1;
    logic  unlink;
    logic  out_load;
    resp_t resp;
    logic  word_next;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_get;
    logic put_active;
    logic put_slot_zero;
    logic tail_empty;
    logic alloc_done;
    logic alloc_found;
    logic spill;
    logic put_last;
    logic len_zero;
    logic word_last;
    logic out_taken;
  } stat_t;

  // Ones in the low n bytes, n saturating at eight
  function automatic logic [DATA_W-1:0] byte_mask(input logic [3:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[i*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

// File: rtl/lsmq_in_if.sv
interface lsmq_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] data;
  logic [3:0]  word_bytes;
  logic        last;
  logic [6:0]  request_bytes;

  modport source (output valid, command, data, word_bytes, last, request_bytes,
                  input ready);
  modport sink (input valid, command, data, word_bytes, last, request_bytes,
                output ready);
endinterface

// File: rtl/lsmq_out_if.sv
interface lsmq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] data_res;
  logic [3:0]  valid_bytes;
  logic        last_res;

  modport source (output valid, status, data_res, valid_bytes, last_res,
                  input ready);
  modport sink (input valid, status, data_res, valid_bytes, last_res,
                output ready);
endinterface

// File: rtl/lsmq_ram.sv
module lsmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lsmq_ctrl.sv
module lsmq_ctrl
  import lsmq_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  stat_t  st,
  output logic   in_ready,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (st.in_fire) begin
          if (st.in_get) begin
            state_nxt = st.tail_empty ? S_GET_EMPTY : S_GET_RD0;
          end else if (!st.put_active) begin
            state_nxt = S_ALLOC;
          end else begin
            state_nxt = st.put_slot_zero ? S_PUT_FULL : S_WLO;
          end
        end
      end
      S_ALLOC: begin
        if (st.alloc_done) state_nxt = st.alloc_found ? S_WLO : S_PUT_FULL;
      end
      S_WLO: begin
        if (st.spill)         state_nxt = S_WHI;
        else if (st.put_last) state_nxt = S_LINK0;
        else                  state_nxt = S_PUT_OK;
      end
      S_WHI:       state_nxt = st.put_last ? S_LINK0 : S_PUT_OK;
      S_LINK0:     state_nxt = S_LINK1;
      S_LINK1:     state_nxt = S_PUT_OK;
      S_PUT_OK:    state_nxt = S_RESP_WAIT;
      S_PUT_FULL:  state_nxt = S_RESP_WAIT;
      S_GET_EMPTY: state_nxt = S_RESP_WAIT;
      S_GET_RD0:   state_nxt = S_GET_RD1;
      S_GET_RD1:   state_nxt = S_UNLINK;
      S_UNLINK:    state_nxt = st.len_zero ? S_GET_ZERO : S_WORD_RD;
      S_GET_ZERO:  state_nxt = S_RESP_WAIT;
      S_WORD_RD:   state_nxt = S_WORD_OUT;
      S_WORD_OUT:  state_nxt = S_WORD_WAIT;
      S_RESP_WAIT: begin
        if (st.out_taken) state_nxt = S_IDLE;
      end
      S_WORD_WAIT: begin
        if (st.out_taken) state_nxt = st.word_last ? S_IDLE : S_WORD_RD;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd      = '0;
    cmd.resp = RESP_OK;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = st.in_fire;
      end
      S_ALLOC: cmd.alloc_step = 1'b1;
      S_WLO:   cmd.put_wlo = 1'b1;
      S_WHI:   cmd.put_whi = 1'b1;
      S_LINK0: cmd.link0 = 1'b1;
      S_LINK1: cmd.link1 = 1'b1;
      S_PUT_OK: begin
        cmd.out_load = 1'b1;
        cmd.resp     = RESP_OK;
      end
      S_PUT_FULL: begin
        cmd.put_full = 1'b1;
        cmd.out_load = 1'b1;
        cmd.resp     = RESP_FULL;
      end
      S_GET_EMPTY: begin
        cmd.out_load = 1'b1;
        cmd.resp     = RESP_EMPTY;
      end
      S_GET_RD0:   ;
      S_GET_RD1:   cmd.get_rd1 = 1'b1;
      S_UNLINK:    cmd.unlink = 1'b1;
      S_GET_ZERO: begin
        cmd.out_load = 1'b1;
        cmd.resp     = RESP_OK;
      end
      S_WORD_RD:   ;
      S_WORD_OUT: begin
        cmd.out_load = 1'b1;
        cmd.resp     = RESP_WORD;
      end
      S_RESP_WAIT: ;
      S_WORD_WAIT: cmd.word_next = st.out_taken && !st.word_last;
      default:     ;
    endcase
  end

endmodule

// File: rtl/lsmq_dp.sv
module lsmq_dp
  import lsmq_pkg::*;
#(
  parameter int SLOTS      = 64,
  parameter int PAGE_SIZE  = 8,
  parameter int PAGES      = 8,
  parameter int UNIT_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic        in_fire,
  input  logic        in_command,
  input  logic [63:0] in_data,
  input  logic [3:0]  in_word_bytes,
  input  logic        in_last,
  input  logic [6:0]  in_request_bytes,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [63:0] out_data_res,
  output logic [3:0]  out_valid_bytes,
  output logic        out_last_res
);

  localparam int SW     = $clog2(SLOTS + 1);
  localparam int LW     = $clog2(UNIT_BYTES + 1);
  localparam int CW     = (LW > 7) ? LW : 7;
  localparam int UW     = (UNIT_BYTES + 7) / 8;
  localparam int PW     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int IW     = (PAGE_SIZE > 1) ? $clog2(PAGE_SIZE) : 1;
  localparam int EXT    = PAGES * PAGE_SIZE;
  localparam int NDEPTH = SLOTS + 1;
  localparam int PDEPTH = NDEPTH * UW;
  localparam int NAW    = $clog2(NDEPTH);
  localparam int PAW    = $clog2(PDEPTH);

  // Occupancy and list state
  logic [SLOTS-1:0]  slot_used_r, slot_used_nxt;
  logic [PAGES-1:0]  page_full_r, page_full_nxt;
  logic [SW-1:0]     tail_r, tail_nxt;
  logic              put_active_r, put_active_nxt;
  logic [SW-1:0]     put_slot_r, put_slot_nxt;
  logic [LW-1:0]     total_r, total_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [PW-1:0]     pg_r, pg_nxt;
  // Get progress
  logic [SW-1:0]     head_r;
  logic [LW-1:0]     len_r;
  logic [WCW-1:0]    words_r;
  logic [KW-1:0]     k_r;
  // Captured item
  logic [63:0]       data_r;
  logic [3:0]        wb_r;
  logic              last_r;
  logic [6:0]        req_r;
  // Result register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [63:0]       out_data_r;
  logic [3:0]        out_vb_r;
  logic              out_last_r;

  // RAM ports
  logic [SW-1:0]     nrd, n_wdata;
  logic [NAW-1:0]    n_waddr, n_raddr;
  logic              n_we;
  logic [LW-1:0]     lrd;
  logic [63:0]       prd, p_wdata;
  logic [PAW-1:0]    p_waddr, p_raddr;
  logic              p_we;

  // Allocation scan
  logic [EXT-1:0]       used_ext;
  logic [PAGE_SIZE-1:0] free_win;
  logic [IW-1:0]        free_idx;
  logic                 page_hit, one_left, last_page;
  logic [SW-1:0]        sel_slot;

  // Put packing
  logic [3:0]   nb8, nput;
  logic [LW-1:0] room;
  logic [2:0]   off;
  logic [3:0]   fill;
  logic [127:0] wide;

  // Get bookkeeping
  logic [SW-1:0]     head_c;
  logic [CW-1:0]     lclamp, len_w;
  logic [LW-1:0]     len_c;
  logic [LW:0]       words_raw;
  logic [WCW-1:0]    words_c;
  logic [LW-1:0]     rem;
  logic [3:0]        vb_c;

  // Page window over the slot flags; slots past the end count as taken
  always_comb begin
    for (int i = 0; i < EXT; i++) begin
      used_ext[i] = (i < SLOTS) ? slot_used_r[i] : 1'b1;
    end
    free_win  = ~used_ext[int'(pg_r) * PAGE_SIZE +: PAGE_SIZE];
    free_idx  = '0;
    for (int i = PAGE_SIZE - 1; i >= 0; i--) begin
      if (free_win[i]) free_idx = IW'(i);
    end
    page_hit  = !page_full_r[pg_r] && (|free_win);
    one_left  = (free_win & (free_win - PAGE_SIZE'(1))) == '0;
    last_page = pg_r == PW'(PAGES - 1);
    sel_slot  = SW'(int'(pg_r) * PAGE_SIZE + int'(free_idx) + 1);
  end

  // Byte packing of one put word into the slot
  always_comb begin
    nb8  = (wb_r > 4'd8) ? 4'd8 : wb_r;
    room = LW'(UNIT_BYTES) - total_r;
    nput = (LW'(nb8) < room) ? nb8 : room[3:0];
    off  = total_r[2:0];
    fill = {1'b0, off} + nput;
    wide = {64'b0, acc_r} | ({64'b0, data_r & byte_mask(nput)} << {off, 3'b000});
  end

  // Head pick and length of the message being removed
  always_comb begin
    head_c    = (nrd == '0 || nrd > SW'(SLOTS)) ? tail_r : nrd;
    lclamp    = (CW'(lrd) > CW'(UNIT_BYTES)) ? CW'(UNIT_BYTES) : CW'(lrd);
    len_w     = (CW'(req_r) < lclamp) ? CW'(req_r) : lclamp;
    len_c     = LW'(len_w);
    words_raw = ({1'b0, len_c} + (LW+1)'(7)) >> 3;
    words_c   = (words_raw > (LW+1)'(MAX_RESULTS)) ? WCW'(MAX_RESULTS) : WCW'(words_raw);
    rem       = len_r - LW'({k_r, 3'b000});
    vb_c      = (rem > LW'(8)) ? 4'd8 : rem[3:0];
  end

  // Flag, pointer and packing state
  always_comb begin
    slot_used_nxt  = slot_used_r;
    page_full_nxt  = page_full_r;
    tail_nxt       = tail_r;
    put_active_nxt = put_active_r;
    put_slot_nxt   = put_slot_r;
    total_nxt      = total_r;
    acc_nxt        = acc_r;
    pg_nxt         = pg_r;

    if (cmd.capture) pg_nxt = '0;

    if (cmd.alloc_step) begin
      if (page_hit) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (i + 1 == int'(sel_slot)) slot_used_nxt[i] = 1'b1;
        end
        if (one_left) page_full_nxt[pg_r] = 1'b1;
      end else begin
        page_full_nxt[pg_r] = 1'b1;
        if (!last_page) pg_nxt = pg_r + PW'(1);
      end
      if (page_hit || last_page) begin
        put_active_nxt = 1'b1;
        put_slot_nxt   = page_hit ? sel_slot : '0;
        total_nxt      = '0;
        acc_nxt        = '0;
      end
    end

    if (cmd.put_wlo) begin
      total_nxt = total_r + LW'(nput);
      acc_nxt   = (fill >= 4'd8) ? wide[127:64] : wide[63:0];
    end

    if (cmd.put_full && last_r) put_active_nxt = 1'b0;

    if (cmd.link1) begin
      tail_nxt       = put_slot_r;
      put_active_nxt = 1'b0;
      put_slot_nxt   = '0;
    end

    // Remove head: fix tail and free its slot and page
    if (cmd.unlink) begin
      if (head_r == tail_r) tail_nxt = '0;
      for (int i = 0; i < SLOTS; i++) begin
        if (i + 1 == int'(head_r)) slot_used_nxt[i] = 1'b0;
      end
      for (int p = 0; p < PAGES; p++) begin
        if (int'(head_r) > p * PAGE_SIZE && int'(head_r) <= (p + 1) * PAGE_SIZE) begin
          page_full_nxt[p] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r  <= '0;
      page_full_r  <= '0;
      tail_r       <= '0;
      put_active_r <= 1'b0;
      put_slot_r   <= '0;
      total_r      <= '0;
      pg_r         <= '0;
      out_valid_r  <= 1'b0;
      k_r          <= '0;
    end else begin
      slot_used_r  <= slot_used_nxt;
      page_full_r  <= page_full_nxt;
      tail_r       <= tail_nxt;
      put_active_r <= put_active_nxt;
      put_slot_r   <= put_slot_nxt;
      total_r      <= total_nxt;
      pg_r         <= pg_nxt;
      if (cmd.out_load)                  out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.unlink)         k_r <= '0;
      else if (cmd.word_next) k_r <= k_r + KW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.capture) begin
      data_r <= in_data;
      wb_r   <= in_word_bytes;
      last_r <= in_last;
      req_r  <= in_request_bytes;
    end
    if (cmd.get_rd1) head_r <= head_c;
    if (cmd.unlink) begin
      len_r   <= len_c;
      words_r <= words_c;
    end
    if (cmd.out_load) begin
      unique case (cmd.resp)
        RESP_OK: begin
          out_status_r <= ST_OK;
          out_data_r   <= '0;
          out_vb_r     <= 4'd0;
          out_last_r   <= 1'b1;
        end
        RESP_FULL: begin
          out_status_r <= ST_FULL;
          out_data_r   <= '0;
          out_vb_r     <= 4'd0;
          out_last_r   <= 1'b1;
        end
        RESP_EMPTY: begin
          out_status_r <= ST_EMPTY;
          out_data_r   <= '0;
          out_vb_r     <= 4'd0;
          out_last_r   <= 1'b1;
        end
        RESP_WORD: begin
          out_status_r <= ST_OK;
          out_data_r   <= prd & byte_mask(vb_c);
          out_vb_r     <= vb_c;
          out_last_r   <= st.word_last;
        end
        default: begin
          out_status_r <= ST_OK;
          out_data_r   <= '0;
          out_vb_r     <= 4'd0;
          out_last_r   <= 1'b1;
        end
      endcase
    end
  end

  // Link RAM: terminate new tail, hook it on old tail, advance head
  always_comb begin
    n_we    = cmd.link0 || cmd.link1 || cmd.unlink;
    n_waddr = '0;
    n_wdata = '0;
    if (cmd.link0) begin
      n_waddr = NAW'(put_slot_r);
    end else if (cmd.link1) begin
      n_waddr = NAW'(tail_r);
      n_wdata = put_slot_r;
    end else if (cmd.unlink) begin
      n_wdata = (head_r == tail_r) ? '0 : nrd;
    end
    n_raddr = cmd.get_rd1 ? NAW'(head_c) : '0;
  end

  // Payload RAM: slot base plus word offset
  always_comb begin
    p_we    = (cmd.put_wlo && nput != 4'd0) || cmd.put_whi;
    p_waddr = PAW'(put_slot_r) * PAW'(UW) + PAW'(total_r >> 3);
    p_wdata = cmd.put_whi ? acc_r : wide[63:0];
    p_raddr = PAW'(head_r) * PAW'(UW) + PAW'(k_r);
  end

  lsmq_ram #(.WIDTH(SW), .DEPTH(NDEPTH)) u_next_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (nrd)
  );

  lsmq_ram #(.WIDTH(LW), .DEPTH(NDEPTH)) u_len_ram (
    .clk   (clk),
    .we    (cmd.link0),
    .waddr (NAW'(put_slot_r)),
    .wdata (total_r),
    .raddr (NAW'(head_c)),
    .rdata (lrd)
  );

  lsmq_ram #(.WIDTH(64), .DEPTH(PDEPTH)) u_payload_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (prd)
  );

  // Status to the controller
  always_comb begin
    st.in_fire       = in_fire;
    st.in_get        = in_command == CMD_GET;
    st.put_active    = put_active_r;
    st.put_slot_zero = put_slot_r == '0;
    st.tail_empty    = tail_r == '0;
    st.alloc_done    = page_hit || last_page;
    st.alloc_found   = page_hit;
    st.spill         = fill > 4'd8;
    st.put_last      = last_r;
    st.len_zero      = len_c == '0;
    st.word_last     = {1'b0, k_r} == (words_r - WCW'(1));
    st.out_taken     = out_valid_r && out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_res    = out_data_r;
  assign out_valid_bytes = out_vb_r;
  assign out_last_res    = out_last_r;

endmodule

// File: rtl/linked_slot_message_queue.sv
// Message FIFO over SLOTS fixed slots of UNIT_BYTES each, linked as a list.
// Each put word and each get is one item, taken one at a time. A put word
// that continues a message is packed into its slot and answered through the
// output register before the input is ready again. A second payload write
// follows when its bytes cross a payload word boundary, and the word marked
// last is then linked onto the list tail. The first word of a message scans
// the pages in turn (up to PAGES) to find a free slot. A word discarded on
// a full queue gets a full status. A get walks the link and length RAMs,
// then reads its payload words one by one from the payload RAM's single read
// port. An empty get and a zero-length get each return a single result.
// Results leave through a registered output that holds until taken; a stall
// at the sink holds up the item.
`include "linked_slot_message_queue_macros.svh"

module linked_slot_message_queue
  import lsmq_pkg::*;
#(
  parameter int SLOTS      = 64,
  parameter int PAGE_SIZE  = 8,
  parameter int PAGES      = 8,
  parameter int UNIT_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  lsmq_in_if.sink    in_ch,
  lsmq_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t st;
  logic  in_ready;
  logic  in_fire;

  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  lsmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  lsmq_dp #(
    .SLOTS      (SLOTS),
    .PAGE_SIZE  (PAGE_SIZE),
    .PAGES      (PAGES),
    .UNIT_BYTES (UNIT_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_fire          (in_fire),
    .in_command       (in_ch.command),
    .in_data          (in_ch.data),
    .in_word_bytes    (in_ch.word_bytes),
    .in_last          (in_ch.last),
    .in_request_bytes (in_ch.request_bytes),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_status       (out_ch.status),
    .out_data_res     (out_ch.data_res),
    .out_valid_bytes  (out_ch.valid_bytes),
    .out_last_res     (out_ch.last_res)
  );

  // An accepted item holds off the input until its results are out
  `LSMQ_ASSERT(a_busy_after_accept, in_fire |=> !in_ch.ready, "input taken while busy")
  // Nothing left pending when a new item may enter
  `LSMQ_ASSERT(a_idle_no_result, in_ch.ready |-> !out_ch.valid, "result pending in idle")
  // Error answers are single, empty results
  `LSMQ_ASSERT(a_error_result,
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.last_res && out_ch.valid_bytes == 4'd0),
    "error result malformed")
  // Reset leaves no result on the output
  `LSMQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_ch.valid, "result after reset")

endmodule
